[src/f12csw_pkg.sv]
package f12csw_pkg;

    // Image and disk geometry.
    localparam int IMAGE_BYTES     = 2048;
    localparam int SECTOR_BYTES    = 512;
    localparam int CLUSTER_SECTORS = 4;
    localparam int DISK_SECTORS    = 256;

    // Fixed layout: boot sector, two FAT sectors and one root directory sector.
    localparam int FAT_BYTES      = 512;
    localparam int FIRST_DATA_LBA = 4;
    localparam int FIRST_CLUSTER  = 2;
    localparam int DATA_CLUSTERS  = (DISK_SECTORS - FIRST_DATA_LBA) / CLUSTER_SECTORS;
    localparam int LAST_CLUSTER   = FIRST_CLUSTER + DATA_CLUSTERS - 1;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int CLUS_W  = 16;
    localparam int ENTRY_W = 12;
    localparam int SIZE_W  = 32;
    localparam int LBA_W   = 8;
    localparam int CNT_W   = 10;
    localparam int STAT_W  = 3;

    // Counter widths.
    localparam int DONE_W = $clog2(IMAGE_BYTES + 1);
    localparam int HOP_W  = $clog2(DATA_CLUSTERS + 1);
    localparam int SEC_W  = $clog2(CLUSTER_SECTORS + 1);

    // Entries at or above this value end the chain.
    localparam logic [ENTRY_W-1:0] END_MARK = 12'hff8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_ENTRY  = 2'd1;
    localparam logic [OP_W-1:0] OP_WALK       = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
    localparam logic [STAT_W-1:0] ST_SIZE_MISMATCH = 3'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_CHAIN_END     = 3'd3;
    localparam logic [STAT_W-1:0] ST_HOPS_EXCEEDED = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_SET_INDEX = 3'd5;

endpackage

[src/fat12_chain_sector_walker_core.sv]
// FAT12 cluster chain walker holding one 512-byte FAT sector.
// Commands are transferred when start is high and busy is low. Each result
// appears for exactly one cycle with o_valid high; the receiver must take it,
// as there is no way to hold results off. o_last marks the final result of a
// command; a command with operation 3 gives no result at all.
// After reset the FAT store is cleared by a pass over all 512 bytes, one byte a
// cycle, during which busy stays high.
// Handling after the command transfer:
//   raw byte write: result on the next cycle, busy never rises.
//   entry set: states S_SET_RD, S_SET_W1 and S_SET_W2 do one read-modify-write
//   of the single RAM port (a bad index answers on the next cycle).
//   walk: a size mismatch answers on the next cycle; else a check per cluster,
//   a pass through S_SECT per emitted sector, and S_E0, S_E1 and S_E2 per
//   followed FAT entry, as each entry needs two byte reads through the registered RAM read port.
//   With the default geometry a fully contiguous image takes one cluster.
// The one RAM port is shared by the clearing pass, the byte writes, the
// entry updates and the chain reads; the index adder by the entry updates and the chain reads.
module fat12_chain_sector_walker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [f12csw_pkg::OP_W-1:0]       i_operation,
    input  logic [f12csw_pkg::IDX_W-1:0]      i_byte_index,
    input  logic [f12csw_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic [f12csw_pkg::CLUS_W-1:0]     i_cluster,
    input  logic [f12csw_pkg::ENTRY_W-1:0]    i_entry_value,
    input  logic [f12csw_pkg::SIZE_W-1:0]     i_declared_size,
    output logic                              o_valid,
    output logic [f12csw_pkg::LBA_W-1:0]      o_sector_lba,
    output logic [f12csw_pkg::CNT_W-1:0]      o_byte_count,
    output logic [f12csw_pkg::STAT_W-1:0]     o_status,
    output logic                              o_last
);
    import f12csw_pkg::*;

    localparam int TRI_W  = CLUS_W + 2;
    localparam int IDXF_W = TRI_W - 1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SET_RD,
        S_SET_W1,
        S_SET_W2,
        S_CHECK,
        S_SECT,
        S_E0,
        S_E1,
        S_E2
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr, n_clr;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ENTRY_W-1:0]   r_val, n_val;
    logic                 r_odd, n_odd;
    logic [CLUS_W-1:0]    r_cluster, n_cluster;
    logic [HOP_W-1:0]     r_hops, n_hops;
    logic [DONE_W-1:0]    r_done, n_done;
    logic [LBA_W-1:0]     r_lba, n_lba;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [BYTE_W-1:0]    r_lo, n_lo;
    logic                 r_valid, n_valid;
    logic [LBA_W-1:0]     r_lba_o, n_lba_o;
    logic [CNT_W-1:0]     r_cnt_o, n_cnt_o;
    logic [STAT_W-1:0]    r_stat_o, n_stat_o;
    logic                 r_last_o, n_last_o;

    // FAT store and its single port.
    logic [BYTE_W-1:0]    r_fat [FAT_BYTES];
    logic [BYTE_W-1:0]    r_rdata;
    logic                 w_mem_we;
    logic [IDX_W-1:0]     w_mem_addr;
    logic [BYTE_W-1:0]    w_mem_wdata;

    // Shared index unit: byte position cluster*3/2.
    logic [CLUS_W-1:0]    w_idx_src;
    logic [TRI_W-1:0]     w_tri;
    logic [IDXF_W-1:0]    w_idx_full;

    // Sector byte count and progress.
    logic [DONE_W-1:0]    w_remain;
    logic [CNT_W-1:0]     w_cnt;
    logic [DONE_W-1:0]    w_done_next;
    logic                 w_last;
    logic [ENTRY_W-1:0]   w_next;
    logic [LBA_W-1:0]     w_first;

    assign busy = (r_state != S_IDLE);

    // Index unit, fed by the command in idle and by the current cluster in a walk.
    assign w_idx_src  = (r_state == S_IDLE) ? i_cluster : r_cluster;
    assign w_tri      = TRI_W'(w_idx_src) + TRI_W'({w_idx_src, 1'b0});
    assign w_idx_full = w_tri[TRI_W-1:1];

    // Bytes taken from the current sector and whether that completes the image.
    assign w_remain    = DONE_W'(IMAGE_BYTES) - r_done;
    assign w_cnt       = (w_remain > DONE_W'(SECTOR_BYTES)) ? CNT_W'(SECTOR_BYTES)
                                                            : CNT_W'(w_remain);
    assign w_done_next = r_done + DONE_W'(w_cnt);
    assign w_last      = (w_done_next == DONE_W'(IMAGE_BYTES));

    // Next entry from the two bytes read; odd clusters start at the high nibble.
    assign w_next  = r_cluster[0] ? {r_rdata, r_lo[7:4]} : {r_rdata[3:0], r_lo};
    assign w_first = LBA_W'(FIRST_DATA_LBA
                            + (int'(r_cluster) - FIRST_CLUSTER) * CLUSTER_SECTORS);

    // Sequencer next-state logic and RAM port control.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_odd       = r_odd;
        n_cluster   = r_cluster;
        n_hops      = r_hops;
        n_done      = r_done;
        n_lba       = r_lba;
        n_sec       = r_sec;
        n_lo        = r_lo;
        n_valid     = 1'b0;
        n_lba_o     = '0;
        n_cnt_o     = '0;
        n_stat_o    = ST_OK;
        n_last_o    = 1'b1;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_idx;
        w_mem_wdata = '0;
        case (r_state)
            S_CLR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr;
                n_clr      = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(FAT_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_operation)
                        OP_WRITE_BYTE: begin
                            w_mem_we    = 1'b1;
                            w_mem_addr  = i_byte_index;
                            w_mem_wdata = i_byte_value;
                            n_valid     = 1'b1;
                        end
                        OP_SET_ENTRY: begin
                            n_val = i_entry_value;
                            n_odd = i_cluster[0];
                            n_idx = w_idx_full[IDX_W-1:0];
                            if (w_idx_full >= IDXF_W'(FAT_BYTES - 1)) begin
                                n_valid  = 1'b1;
                                n_stat_o = ST_BAD_SET_INDEX;
                            end else begin
                                n_state = S_SET_RD;
                            end
                        end
                        OP_WALK: begin
                            if (i_declared_size != SIZE_W'(IMAGE_BYTES)) begin
                                n_valid  = 1'b1;
                                n_stat_o = ST_SIZE_MISMATCH;
                            end else begin
                                n_cluster = i_cluster;
                                n_hops    = '0;
                                n_done    = '0;
                                n_state   = S_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Read the byte that shares a nibble with the neighbouring entry.
            S_SET_RD: begin
                w_mem_addr = r_odd ? r_idx : r_idx + IDX_W'(1);
                n_state    = S_SET_W1;
            end
            S_SET_W1: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_odd ? r_idx : r_idx + IDX_W'(1);
                w_mem_wdata = r_odd ? {r_val[3:0], r_rdata[3:0]}
                                    : {r_rdata[7:4], r_val[11:8]};
                n_state     = S_SET_W2;
            end
            S_SET_W2: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_odd ? r_idx + IDX_W'(1) : r_idx;
                w_mem_wdata = r_odd ? r_val[11:4] : r_val[7:0];
                n_valid     = 1'b1;
                n_state     = S_IDLE;
            end
            // Hop limit and cluster range check before a cluster is used.
            S_CHECK: begin
                if (r_hops == HOP_W'(DATA_CLUSTERS)) begin
                    n_valid  = 1'b1;
                    n_stat_o = ST_HOPS_EXCEEDED;
                    n_state  = S_IDLE;
                end else if (r_cluster < CLUS_W'(FIRST_CLUSTER)
                             || r_cluster > CLUS_W'(LAST_CLUSTER)) begin
                    n_valid  = 1'b1;
                    n_stat_o = ST_OUT_OF_RANGE;
                    n_state  = S_IDLE;
                end else begin
                    n_lba   = w_first;
                    n_sec   = '0;
                    n_state = S_SECT;
                end
            end
            // One sector result per cycle.
            S_SECT: begin
                n_valid  = 1'b1;
                n_lba_o  = r_lba;
                n_cnt_o  = w_cnt;
                n_last_o = w_last;
                n_done   = w_done_next;
                n_lba    = r_lba + LBA_W'(1);
                n_sec    = r_sec + SEC_W'(1);
                if (w_last) begin
                    n_state = S_IDLE;
                end else if (r_sec == SEC_W'(CLUSTER_SECTORS - 1)) begin
                    n_state = S_E0;
                end
            end
            // Fetch the two bytes of the current cluster's entry.
            S_E0: begin
                w_mem_addr = w_idx_full[IDX_W-1:0];
                n_state    = S_E1;
            end
            S_E1: begin
                w_mem_addr = w_idx_full[IDX_W-1:0] + IDX_W'(1);
                n_lo       = r_rdata;
                n_state    = S_E2;
            end
            S_E2: begin
                if (w_next >= END_MARK) begin
                    n_valid  = 1'b1;
                    n_stat_o = ST_CHAIN_END;
                    n_state  = S_IDLE;
                end else begin
                    n_cluster = CLUS_W'(w_next);
                    n_hops    = r_hops + HOP_W'(1);
                    n_state   = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_odd     <= n_odd;
        r_cluster <= n_cluster;
        r_hops    <= n_hops;
        r_done    <= n_done;
        r_lba     <= n_lba;
        r_sec     <= n_sec;
        r_lo      <= n_lo;
        r_lba_o   <= n_lba_o;
        r_cnt_o   <= n_cnt_o;
        r_stat_o  <= n_stat_o;
        r_last_o  <= n_last_o;
    end

    // FAT store with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fat[w_mem_addr] <= w_mem_wdata;
        end
        r_rdata <= r_fat[w_mem_addr];
    end

    assign o_valid      = r_valid;
    assign o_sector_lba = r_lba_o;
    assign o_byte_count = r_cnt_o;
    assign o_status     = r_stat_o;
    assign o_last       = r_last_o;

    // An error result always ends its command.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last)
        else $error("Error result transferred without last.");

    // A non-final result means the walk is still running.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("Walk went idle before its final result.");

    // Sector results carry status ok and lie in the data area.
    a_sector_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_count != '0)
            |-> (o_status == ST_OK && o_sector_lba >= LBA_W'(FIRST_DATA_LBA)))
        else $error("Sector result with bad status or sector number.");

    // No result is transferred during the clearing pass.
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> !o_valid)
        else $error("Result transferred while clearing the FAT store.");

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import f12csw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 160;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    // The one operation code that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One command as it is presented to the block.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   byte_index;
        logic [BYTE_W-1:0]  byte_value;
        logic [CLUS_W-1:0]  cluster;
        logic [ENTRY_W-1:0] entry_value;
        logic [SIZE_W-1:0]  declared_size;
    } t_fat_cmd;

    // One result strobe.
    typedef struct packed {
        logic [LBA_W-1:0]  lba;
        logic [CNT_W-1:0]  cnt;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_fat_result;

    // A row of the directed table; typed rows carry a status read straight off the command.
    typedef struct packed {
        t_fat_cmd          cmd;
        logic              typed_check;
        logic [STAT_W-1:0] typed_status;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation     = '0;
    logic [IDX_W-1:0]    i_byte_index    = '0;
    logic [BYTE_W-1:0]   i_byte_value    = '0;
    logic [CLUS_W-1:0]   i_cluster       = '0;
    logic [ENTRY_W-1:0]  i_entry_value   = '0;
    logic [SIZE_W-1:0]   i_declared_size = '0;
    logic                o_valid;
    logic [LBA_W-1:0]    o_sector_lba;
    logic [CNT_W-1:0]    o_byte_count;
    logic [STAT_W-1:0]   o_status;
    logic                o_last;

    logic [BYTE_W-1:0]   fat_mirror [FAT_BYTES];
    t_fat_result         predicted [$];
    t_fat_result         pending_results [$];
    t_directed_row       directed_rows [$];
    t_fat_result         wanted;
    int unsigned         mismatches  = 0;
    int unsigned         cycle_count = 0;

    fat12_chain_sector_walker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_byte_index    (i_byte_index),
        .i_byte_value    (i_byte_value),
        .i_cluster       (i_cluster),
        .i_entry_value   (i_entry_value),
        .i_declared_size (i_declared_size),
        .o_valid         (o_valid),
        .o_sector_lba    (o_sector_lba),
        .o_byte_count    (o_byte_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic t_fat_result make_result(input int unsigned lba, input int unsigned cnt,
                                                input logic [STAT_W-1:0] st, input logic fin);
        t_fat_result r;
        r.lba    = lba[LBA_W-1:0];
        r.cnt    = cnt[CNT_W-1:0];
        r.status = st;
        r.last   = fin;
        return r;
    endfunction

    // Reads the packed 12-bit entry of a cluster from the mirrored FAT.
    function automatic logic [ENTRY_W-1:0] fat_entry(input int unsigned c);
        int unsigned lo_idx;
        int unsigned hi_idx;
        lo_idx = (c * 3 / 2) % FAT_BYTES;
        hi_idx = (lo_idx + 1) % FAT_BYTES;
        if (c[0])
            return {fat_mirror[hi_idx], fat_mirror[lo_idx][7:4]};
        return {fat_mirror[hi_idx][3:0], fat_mirror[lo_idx]};
    endfunction

    // Updates the mirrored FAT and lists the results that one command should give.
    function automatic void predict_fat_response(input t_fat_cmd cmd);
        int unsigned        idx;
        int unsigned        cur;
        int unsigned        done;
        int unsigned        hops;
        int unsigned        first;
        int unsigned        cnt;
        int unsigned        s;
        logic [ENTRY_W-1:0] next_entry;
        bit                 finished;
        predicted.delete();
        case (cmd.op)
            OP_WRITE_BYTE: begin
                fat_mirror[cmd.byte_index] = cmd.byte_value;
                predicted.push_back(make_result(0, 0, ST_OK, 1'b1));
            end
            OP_SET_ENTRY: begin
                idx = cmd.cluster * 3 / 2;
                if (idx + 1 >= FAT_BYTES) begin
                    predicted.push_back(make_result(0, 0, ST_BAD_SET_INDEX, 1'b1));
                end else begin
                    // Odd clusters take the low byte's upper nibble; its lower nibble stays with their neighbour.
                    if (cmd.cluster[0]) begin
                        fat_mirror[idx]     = {cmd.entry_value[3:0], fat_mirror[idx][3:0]};
                        fat_mirror[idx + 1] = cmd.entry_value[11:4];
                    end else begin
                        fat_mirror[idx]     = cmd.entry_value[7:0];
                        fat_mirror[idx + 1] = {fat_mirror[idx + 1][7:4], cmd.entry_value[11:8]};
                    end
                    predicted.push_back(make_result(0, 0, ST_OK, 1'b1));
                end
            end
            OP_WALK: begin
                if (cmd.declared_size != SIZE_W'(IMAGE_BYTES)) begin
                    predicted.push_back(make_result(0, 0, ST_SIZE_MISMATCH, 1'b1));
                    return;
                end
                cur      = 32'(cmd.cluster);
                done     = 0;
                finished = 1'b0;
                for (hops = 0; hops < DATA_CLUSTERS && !finished; hops++) begin
                    if (cur < FIRST_CLUSTER || cur > LAST_CLUSTER) begin
                        predicted.push_back(make_result(0, 0, ST_OUT_OF_RANGE, 1'b1));
                        finished = 1'b1;
                    end else begin
                        // Emit the sectors of this cluster until the image is covered.
                        first = FIRST_DATA_LBA + (cur - FIRST_CLUSTER) * CLUSTER_SECTORS;
                        for (s = 0; s < CLUSTER_SECTORS && done < IMAGE_BYTES; s++) begin
                            cnt = IMAGE_BYTES - done;
                            if (cnt > SECTOR_BYTES)
                                cnt = SECTOR_BYTES;
                            done += cnt;
                            predicted.push_back(make_result(first + s, cnt, ST_OK,
                                                            done == IMAGE_BYTES));
                        end
                        if (done == IMAGE_BYTES) begin
                            finished = 1'b1;
                        end else begin
                            next_entry = fat_entry(cur);
                            if (next_entry >= END_MARK) begin
                                predicted.push_back(make_result(0, 0, ST_CHAIN_END, 1'b1));
                                finished = 1'b1;
                            end else begin
                                cur = 32'(next_entry);
                            end
                        end
                    end
                end
                if (!finished)
                    predicted.push_back(make_result(0, 0, ST_HOPS_EXCEEDED, 1'b1));
            end
            default: begin
                // The unused operation is silently dropped.
            end
        endcase
    endfunction

    function automatic t_directed_row directed_row(
        input logic [OP_W-1:0] op, input int unsigned bidx, input int unsigned bval,
        input int unsigned cl, input int unsigned ent, input logic [SIZE_W-1:0] size,
        input logic typed, input logic [STAT_W-1:0] st);
        t_directed_row row;
        row.cmd.op            = op;
        row.cmd.byte_index    = bidx[IDX_W-1:0];
        row.cmd.byte_value    = bval[BYTE_W-1:0];
        row.cmd.cluster       = cl[CLUS_W-1:0];
        row.cmd.entry_value   = ent[ENTRY_W-1:0];
        row.cmd.declared_size = size;
        row.typed_check       = typed;
        row.typed_status      = st;
        return row;
    endfunction

    // Mostly short gaps, a few long ones, none at all during a burst.
    function automatic int pick_gap(input bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 2);
        if (r < 9)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Presents one command, waits for its transfer, then records what should come back.
    task automatic issue_command(input t_fat_cmd cmd, input logic typed,
                                 input logic [STAT_W-1:0] st, input int gap, input bit drain);
        start           <= 1'b1;
        i_operation     <= cmd.op;
        i_byte_index    <= cmd.byte_index;
        i_byte_value    <= cmd.byte_value;
        i_cluster       <= cmd.cluster;
        i_entry_value   <= cmd.entry_value;
        i_declared_size <= cmd.declared_size;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        predict_fat_response(cmd);
        if (typed) begin
            pending_results.push_back(make_result(0, 0, st, 1'b1));
        end else begin
            foreach (predicted[k])
                pending_results.push_back(predicted[k]);
        end
        if (gap > 0 || drain) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                do
                    @(posedge i_clk);
                while (pending_results.size() != 0);
            end
        end
    endtask

    // Result checker: every strobe must match the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: lba %0d count %0d status %0d last %0d",
                             o_sector_lba, o_byte_count, o_status, o_last);
            end else begin
                wanted = pending_results.pop_front();
                if (o_sector_lba !== wanted.lba || o_byte_count !== wanted.cnt ||
                    o_status !== wanted.status || o_last !== wanted.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch: expected lba %0d count %0d status %0d last %0d",
                                 wanted.lba, wanted.cnt, wanted.status, wanted.last);
                        $display("                 got lba %0d count %0d status %0d last %0d",
                                 o_sector_lba, o_byte_count, o_status, o_last);
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        t_fat_cmd    cmd;
        int unsigned sent;
        int unsigned kind;
        bit          burst;

        for (int i = 0; i < FAT_BYTES; i++)
            fat_mirror[i] = '0;

        // Directed table: extremes of every field, every operation and the size, range and set-index error paths.
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, IMAGE_BYTES, 1'b0, ST_OK));
        directed_rows.push_back(directed_row(OP_WRITE_BYTE, 0, 255, 0, 0, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_WRITE_BYTE, 511, 0, 0, 0, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_WRITE_BYTE, 170, 85, 0, 0, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 0, 0, 0, 4095, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 0, 0, 3, 0, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 0, 0, 340, 2748, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 0, 0, 341, 291, 0, 1'b1,
                                             ST_BAD_SET_INDEX));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 0, 0, 342, 4095, 0, 1'b1,
                                             ST_BAD_SET_INDEX));
        directed_rows.push_back(directed_row(OP_SET_ENTRY, 511, 255, 65535, 4095, 32'hffffffff,
                                             1'b1, ST_BAD_SET_INDEX));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, 0, 1'b1, ST_SIZE_MISMATCH));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, 32'hffffffff, 1'b1,
                                             ST_SIZE_MISMATCH));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, IMAGE_BYTES - 1, 1'b1,
                                             ST_SIZE_MISMATCH));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, IMAGE_BYTES + 1, 1'b1,
                                             ST_SIZE_MISMATCH));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 0, 0, IMAGE_BYTES, 1'b1,
                                             ST_OUT_OF_RANGE));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 1, 0, IMAGE_BYTES, 1'b1,
                                             ST_OUT_OF_RANGE));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, LAST_CLUSTER + 1, 0, IMAGE_BYTES,
                                             1'b1, ST_OUT_OF_RANGE));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 65535, 0, IMAGE_BYTES, 1'b1,
                                             ST_OUT_OF_RANGE));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, LAST_CLUSTER, 0, IMAGE_BYTES,
                                             1'b0, ST_OK));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 33, 0, IMAGE_BYTES, 1'b0, ST_OK));
        directed_rows.push_back(directed_row(OP_UNUSED, 511, 255, 65535, 4095, 32'hffffffff,
                                             1'b0, ST_OK));
        directed_rows.push_back(directed_row(OP_WRITE_BYTE, 511, 255, 0, 0, 0, 1'b1, ST_OK));
        directed_rows.push_back(directed_row(OP_WALK, 0, 0, 2, 0, IMAGE_BYTES, 1'b0, ST_OK));

        // Hold reset, then release it; the block clears its FAT with busy high.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, draining at the end so the random part starts from quiet.
        foreach (directed_rows[r])
            issue_command(directed_rows[r].cmd, directed_rows[r].typed_check,
                          directed_rows[r].typed_status, pick_gap(1'b0),
                          r == directed_rows.size() - 1);

        // Random part: mostly well-formed walks and FAT updates, some noise.
        sent  = 0;
        burst = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            cmd.op            = OP_WALK;
            cmd.byte_index    = IDX_W'($urandom_range(0, FAT_BYTES - 1));
            cmd.byte_value    = BYTE_W'($urandom_range(0, 255));
            cmd.cluster       = CLUS_W'($urandom_range(0, 65535));
            cmd.entry_value   = ENTRY_W'($urandom_range(0, 4095));
            cmd.declared_size = $urandom;
            kind              = $urandom_range(0, 99);
            if (kind < 35) begin
                cmd.cluster       = CLUS_W'($urandom_range(FIRST_CLUSTER, LAST_CLUSTER));
                cmd.declared_size = SIZE_W'(IMAGE_BYTES);
            end else if (kind < 45) begin
                if ($urandom_range(0, 1) == 0)
                    cmd.cluster = CLUS_W'($urandom_range(0, LAST_CLUSTER + 16));
                if ($urandom_range(0, 1) == 0)
                    cmd.declared_size = SIZE_W'(IMAGE_BYTES);
            end else if (kind < 70) begin
                cmd.op = OP_SET_ENTRY;
                if ($urandom_range(0, 4) != 0)
                    cmd.cluster = CLUS_W'($urandom_range(0, 345));
            end else if (kind < 94) begin
                cmd.op = OP_WRITE_BYTE;
            end else begin
                cmd.op = OP_UNUSED;
            end
            if (cmd.op != OP_UNUSED)
                sent++;
            // Halfway through and at the end, hold off until every outstanding result has come back.
            issue_command(cmd, 1'b0, ST_OK, pick_gap(burst),
                          sent == RANDOM_ITEMS / 2 || sent == RANDOM_ITEMS);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
